### rtl/core/kamqa_pkg.sv
// Package with types and codes for the kind-aware message queue admission block.
`timescale 1ns / 1ps
package kamqa_pkg;

   localparam logic [1:0] FUNC_PUBLISH = 2'd0;
   localparam logic [1:0] FUNC_TAKE    = 2'd1;
   localparam logic [1:0] FUNC_RELEASE = 2'd2;
   localparam logic [1:0] FUNC_FLUSH   = 2'd3;

   localparam logic [1:0] KIND_LOG   = 2'd0;
   localparam logic [1:0] KIND_STATE = 2'd1;
   localparam logic [1:0] KIND_DISC  = 2'd2;

   localparam logic [2:0] EV_ACCEPTED = 3'd0;
   localparam logic [2:0] EV_BAD_LEN  = 3'd1;
   localparam logic [2:0] EV_NO_CLIENT = 3'd2;
   localparam logic [2:0] EV_FULL     = 3'd3;
   localparam logic [2:0] EV_EVICTED  = 3'd4;
   localparam logic [2:0] EV_TAKEN    = 3'd5;
   localparam logic [2:0] EV_EMPTY    = 3'd6;
   localparam logic [2:0] EV_RELEASED = 3'd7;

   localparam logic CSR_BYTE_BUDGET = 1'b0;
   localparam logic CSR_FRAME_LIMIT = 1'b1;

   typedef struct packed {
      logic [1:0]  func;
      logic [1:0]  msg_kind;
      logic [15:0] msg_tag;
      logic [15:0] msg_length;
      logic        has_client;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [15:0] tag;
      logic [1:0]  kind;
      logic [16:0] cost;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] tag;
      logic [1:0]  kind;
      logic [16:0] cost;
   } entry_type;

   // Command from the sequencer to every cell of the chain.
   typedef struct packed {
      logic      shift;   // cells at or above pos take their upper neighbor
      logic      append;  // the cell at pos loads the new entry
      entry_type fresh;
   } chain_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DROP,
      ST_EVICT,
      ST_FINAL,
      ST_FLUSH
   } state_type;

endpackage

### rtl/core/kamqa_cell.sv
// One queue slot of the descriptor chain.
`timescale 1ns / 1ps
module kamqa_cell (
   input  logic                    clock,
   input  logic                    shift_en,
   input  logic                    load_en,
   input  kamqa_pkg::entry_type    upper,
   input  kamqa_pkg::entry_type    fresh,
   output kamqa_pkg::entry_type    value
);
   import kamqa_pkg::*;

   entry_type value_ff;
   entry_type value_in;

   always_comb begin
      value_in = value_ff;
      if (load_en) begin
         value_in = fresh;
      end else if (shift_en) begin
         value_in = upper;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

### rtl/core/kind_aware_message_queue_admission.sv
// Top level of the kind-aware message queue admission block.
//
// Commands enter on the req_ channel: an item is taken when start is high
// and busy is low. Results leave on the rsp_ channel one per cycle, each
// marked by rsp_valid for one cycle; rsp_data.last flags the final result
// of an item. The receiver cannot stall, so results are never held.
// Configuration is written on the csr_ channel (index 0 byte budget,
// index 1 frame limit); csr_ready is always high.
// Descriptors sit in a chain of QUEUE_DEPTH cells; removing an entry shifts
// every cell above it down by one neighbor, all cells together.
// A take, release or rejected publish puts its result out in the cycle that
// follows the accepting edge. A log publish gives its result from ST_FINAL.
// A state or discovery publish makes one pass to drop entries of its kind,
// then, while the queue is still full, at most one pass evicting logs oldest
// first and, for discovery, one evicting states oldest first; its final
// result comes from ST_FINAL. A flush gives one result per cycle until the
// queue is empty.
// The sequencer works on one item at a time and holds busy high.
// Reset empties the queue, clears the in-flight slot and loads the
// register defaults; no clearing pass is needed since cells are only read
// below the fill count.
`timescale 1ns / 1ps
module kind_aware_message_queue_admission #(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  kamqa_pkg::req_type   req_data,
   output logic                 rsp_valid,
   output kamqa_pkg::rsp_type   rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_index,
   input  logic [15:0]          csr_wdata
);
   import kamqa_pkg::*;

   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [15:0] budget_ff, budget_in, limit_ff, limit_in;
   state_type   state_ff, state_in;
   req_type     req_ff, req_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [16:0] total_ff, total_in;
   logic        fvalid_ff, fvalid_in;
   entry_type   flight_ff, flight_in;
   logic        rvalid_ff, rvalid_in;
   rsp_type     rsp_ff, rsp_in;
   logic        search_state_ff, search_state_in;

   chain_cmd_type cmd;
   entry_type     cells [QUEUE_DEPTH];
   entry_type     uppers [QUEUE_DEPTH];

   genvar g;
   generate
      for (g = 0; g < QUEUE_DEPTH; g++) begin : g_chain
         if (g == QUEUE_DEPTH - 1) begin : g_top
            assign uppers[g] = '0;
         end else begin : g_mid
            assign uppers[g] = cells[g+1];
         end
         kamqa_cell u_cell (
            .clock    (clock),
            .shift_en (cmd.shift && (CW'(g) >= pos_ff)),
            .load_en  (cmd.append && (CW'(g) == pos_ff)),
            .upper    (uppers[g]),
            .fresh    (cmd.fresh),
            .value    (cells[g])
         );
      end
   endgenerate

   entry_type   cur;
   logic [16:0] new_cost;
   logic [17:0] need;
   logic        full;

   always_comb begin
      cur      = cells[pos_ff[IW-1:0]];
      new_cost = {1'b0, req_ff.msg_length} + 17'd1;
      need     = {1'b0, total_ff} + {1'b0, new_cost};
      full     = (count_ff == CW'(QUEUE_DEPTH)) || (need > {2'b0, budget_ff});
   end

   function automatic logic [16:0] sub_sat(logic [16:0] a, logic [16:0] b);
      return (a >= b) ? (a - b) : 17'd0;
   endfunction

   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      total_in  = total_ff;
      fvalid_in = fvalid_ff;
      flight_in = flight_ff;
      rvalid_in = 1'b0;
      rsp_in    = '0;
      search_state_in = search_state_ff;
      cmd       = '0;
      cmd.fresh = '{tag: req_ff.msg_tag, kind: req_ff.msg_kind, cost: new_cost};
      budget_in = budget_ff;
      limit_in  = limit_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_BYTE_BUDGET: budget_in = csr_wdata;
            CSR_FRAME_LIMIT: limit_in  = csr_wdata;
            default: ;
         endcase
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_data;
               pos_in = '0;
               search_state_in = 1'b0;
               rvalid_in = 1'b1;
               rsp_in.last = 1'b1;
               unique case (req_data.func)
                  FUNC_PUBLISH: begin
                     rvalid_in = 1'b0;
                     rsp_in.last = 1'b0;
                     if (req_data.msg_kind > KIND_DISC || req_data.msg_length == 16'd0 ||
                         req_data.msg_length >= limit_ff) begin
                        rvalid_in = 1'b1;
                        rsp_in.last = 1'b1;
                        rsp_in.event_res = EV_BAD_LEN;
                     end else if (!req_data.has_client) begin
                        rvalid_in = 1'b1;
                        rsp_in.last = 1'b1;
                        rsp_in.event_res = EV_NO_CLIENT;
                     end else if (req_data.msg_kind == KIND_LOG) begin
                        state_in = ST_FINAL;
                     end else begin
                        state_in = ST_DROP;
                     end
                  end
                  FUNC_TAKE: begin
                     if (count_ff == '0 || fvalid_ff) begin
                        rsp_in.event_res = EV_EMPTY;
                     end else begin
                        rsp_in.event_res = EV_TAKEN;
                        rsp_in.tag  = cells[0].tag;
                        rsp_in.kind = cells[0].kind;
                        rsp_in.cost = cells[0].cost;
                        fvalid_in = 1'b1;
                        flight_in = cells[0];
                        cmd.shift = 1'b1;
                        count_in  = count_ff - CW'(1);
                     end
                  end
                  FUNC_RELEASE: begin
                     if (!fvalid_ff) begin
                        rsp_in.event_res = EV_EMPTY;
                     end else begin
                        rsp_in.event_res = EV_RELEASED;
                        rsp_in.tag  = flight_ff.tag;
                        rsp_in.kind = flight_ff.kind;
                        rsp_in.cost = flight_ff.cost;
                        total_in  = sub_sat(total_ff, flight_ff.cost);
                        fvalid_in = 1'b0;
                        flight_in = '0;
                     end
                  end
                  FUNC_FLUSH: begin
                     if (count_ff == '0) begin
                        rsp_in.event_res = EV_EMPTY;
                     end else begin
                        rvalid_in = 1'b0;
                        rsp_in.last = 1'b0;
                        state_in = ST_FLUSH;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_DROP: begin
            // Walk the chain once, removing entries of the new item's kind.
            if (pos_ff >= count_ff) begin
               pos_in = '0;
               state_in = ST_EVICT;
            end else if (cur.kind == req_ff.msg_kind) begin
               rvalid_in = 1'b1;
               rsp_in = '{event_res: EV_EVICTED, tag: cur.tag, kind: cur.kind,
                          cost: cur.cost, last: 1'b0};
               total_in = sub_sat(total_ff, cur.cost);
               cmd.shift = 1'b1;
               count_in = count_ff - CW'(1);
            end else begin
               pos_in = pos_ff + CW'(1);
            end
         end
         ST_EVICT: begin
            // While full, evict logs oldest first, then (discovery only) states.
            // Entries below pos never match, so a removal keeps the position.
            if (!full) begin
               state_in = ST_FINAL;
            end else if (pos_ff >= count_ff) begin
               if (!search_state_ff && req_ff.msg_kind == KIND_DISC) begin
                  search_state_in = 1'b1;
                  pos_in = '0;
               end else begin
                  state_in = ST_FINAL;
               end
            end else if (cur.kind == (search_state_ff ? KIND_STATE : KIND_LOG)) begin
               rvalid_in = 1'b1;
               rsp_in = '{event_res: EV_EVICTED, tag: cur.tag, kind: cur.kind,
                          cost: cur.cost, last: 1'b0};
               total_in = sub_sat(total_ff, cur.cost);
               cmd.shift = 1'b1;
               count_in = count_ff - CW'(1);
            end else begin
               pos_in = pos_ff + CW'(1);
            end
         end
         ST_FINAL: begin
            rvalid_in = 1'b1;
            rsp_in.last = 1'b1;
            state_in = ST_IDLE;
            pos_in = '0;
            if (full) begin
               rsp_in.event_res = EV_FULL;
            end else begin
               rsp_in.event_res = EV_ACCEPTED;
               cmd.append = 1'b1;
               count_in = count_ff + CW'(1);
               total_in = need[16:0];
            end
         end
         ST_FLUSH: begin
            rvalid_in = 1'b1;
            rsp_in = '{event_res: EV_EVICTED, tag: cells[0].tag, kind: cells[0].kind,
                       cost: cells[0].cost, last: (count_ff == CW'(1))};
            total_in = sub_sat(total_ff, cells[0].cost);
            cmd.shift = 1'b1;
            count_in = count_ff - CW'(1);
            if (count_ff == CW'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // The append position is registered on entry to ST_FINAL, so the cells
   // see pos_ff at the fill count; ST_FINAL therefore appends at the current count.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         pos_ff    <= '0;
         total_ff  <= '0;
         fvalid_ff <= 1'b0;
         flight_ff <= '0;
         rvalid_ff <= 1'b0;
         budget_ff <= 16'd16384;
         limit_ff  <= 16'd4096;
         search_state_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         pos_ff    <= (state_in == ST_FINAL) ? count_in : pos_in;
         total_ff  <= total_in;
         fvalid_ff <= fvalid_in;
         flight_ff <= flight_in;
         rvalid_ff <= rvalid_in;
         budget_ff <= budget_in;
         limit_ff  <= limit_in;
         search_state_ff <= search_state_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rvalid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("fill count beyond depth");
   a_final_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINAL) |=> (rsp_valid && rsp_data.last && !busy))
      else $error("publish did not close with a final result");
   a_take_flight: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.event_res == EV_TAKEN) |-> fvalid_ff)
      else $error("take without in-flight slot");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.func != FUNC_PUBLISH && req_data.func != FUNC_FLUSH)
      |=> (rsp_valid && rsp_data.last))
      else $error("single-result command missed its result");
`endif

endmodule
